// File: rtl/bdus_pkg.sv
`timescale 1ns / 1ps

package bdus_pkg;

   // Field widths of one request and one response.
   localparam int YEAR_W   = 8;
   localparam int MONTH_W  = 5;
   localparam int DAY_W    = 6;
   localparam int HOUR_W   = 6;
   localparam int MINUTE_W = 7;
   localparam int SECOND_W = 7;
   localparam int EPOCH_W  = 32;

   // Decoded BCD values stay below 166, so eight bits hold any of them.
   localparam int DEC_W = 8;

   localparam int SEC_PER_DAY       = 86400;
   localparam int SEC_PER_HOUR      = 3600;
   localparam int SEC_PER_MIN       = 60;
   localparam int BASE_YEAR         = 2000;
   localparam int EPOCH_YEAR_BEFORE = 1969;
   localparam int DAYS_PER_YEAR     = 365;

   // Two BCD digits of the year decode to at most 15*10+15.
   localparam int YEAR_ENTRIES  = 166;
   localparam int YEAR_IDX_W    = $clog2(YEAR_ENTRIES);
   localparam int YEAR_DAYS_W   = 17;
   localparam int MONTH_ENTRIES = 13;
   localparam int MONTH_IDX_W   = $clog2(MONTH_ENTRIES);
   localparam int MONTH_DAYS_W  = 9;
   localparam int LAST_MONTH    = 12;
   localparam int MARCH_IDX     = 2;

   typedef logic [YEAR_DAYS_W-1:0]  year_days_type  [YEAR_ENTRIES];
   typedef logic [MONTH_DAYS_W-1:0] month_days_type [MONTH_ENTRIES];
   typedef logic [YEAR_ENTRIES-1:0] leap_flags_type;

   typedef struct packed {
      logic [YEAR_W-1:0]   year_bcd;
      logic [MONTH_W-1:0]  month_bcd;
      logic [DAY_W-1:0]    day_bcd;
      logic [HOUR_W-1:0]   hour_bcd;
      logic [MINUTE_W-1:0] minute_bcd;
      logic [SECOND_W-1:0] second_bcd;
   } req_item_type;

   // Count of Gregorian leap years in 1..y.
   function automatic int leaps_upto(input int y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   function automatic bit is_leap(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // Days from 1970-01-01 to January 1st of each year 2000+yy.
   function automatic year_days_type build_year_days();
      year_days_type tbl;
      int            last;
      for (int i = 0; i < YEAR_ENTRIES; i++) begin
         last   = BASE_YEAR + i - 1;
         tbl[i] = YEAR_DAYS_W'(DAYS_PER_YEAR * (last - EPOCH_YEAR_BEFORE)
                  + leaps_upto(last) - leaps_upto(EPOCH_YEAR_BEFORE));
      end
      return tbl;
   endfunction

   function automatic leap_flags_type build_leap_flags();
      leap_flags_type flags;
      for (int i = 0; i < YEAR_ENTRIES; i++) begin
         flags[i] = is_leap(BASE_YEAR + i);
      end
      return flags;
   endfunction

   localparam year_days_type  YEAR_DAYS  = build_year_days();
   localparam leap_flags_type LEAP_FLAGS = build_leap_flags();

   localparam month_days_type DAYS_BEFORE_MONTH = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   // Tens digit is everything above bit 3, weighted by ten even when above nine.
   function automatic logic [DEC_W-1:0] bcd_decode(input logic [DEC_W-1:0] v);
      return DEC_W'(v[DEC_W-1:4]) * DEC_W'(10) + DEC_W'(v[3:0]);
   endfunction

endpackage

// File: rtl/bdus_if.sv
`timescale 1ns / 1ps

interface bdus_req_if;
   import bdus_pkg::*;

   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year_bcd;
   logic [MONTH_W-1:0]  month_bcd;
   logic [DAY_W-1:0]    day_bcd;
   logic [HOUR_W-1:0]   hour_bcd;
   logic [MINUTE_W-1:0] minute_bcd;
   logic [SECOND_W-1:0] second_bcd;

   modport source (
      output valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd,
      input  ready
   );
   modport sink (
      input  valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd,
      output ready
   );
endinterface

interface bdus_rsp_if;
   import bdus_pkg::*;

   logic               valid;
   logic               ready;
   logic [EPOCH_W-1:0] epoch_seconds;

   modport source (
      output valid, epoch_seconds,
      input  ready
   );
   modport sink (
      input  valid, epoch_seconds,
      output ready
   );
endinterface

// File: rtl/bcd_date_to_unix_seconds.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// req      in   valid / ready      year, month, day, hour, minute, second (BCD)
// rsp      out  valid / ready      epoch_seconds (32 bits)
//
// Each request is captured in an input register, converted by one pass of
// combinational logic (BCD decode, year and month tables, constant multiplies
// by 86400, 3600 and 60 and a few adds) and lands in the response register.
// An accepted request moves on from the input register to the response register;
// one request can be accepted in every cycle while the response is not stalled.
// Reset clears both valid flags; the payload registers are not reset.
// A stalled response holds both stages; the input stage still takes a request
// while it is empty or while its contents move into the response register.
module bcd_date_to_unix_seconds (
   input  logic        clock,
   input  logic        reset,
   bdus_req_if.sink    req,
   bdus_rsp_if.source  rsp
);
   import bdus_pkg::*;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   req_item_type       s1_item_ff;
   req_item_type       s1_item_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [EPOCH_W-1:0] rsp_epoch_ff;
   logic [EPOCH_W-1:0] rsp_epoch_in;
   logic [EPOCH_W-1:0] calc_epoch;
   logic               rsp_load;
   logic               s1_load;

   // The converter sits between the input register and the response register.
   bdus_calc u_calc (
      .item          (s1_item_ff),
      .epoch_seconds (calc_epoch)
   );

   always_comb begin
      // The response register can take new data when it is empty or being drained.
      rsp_load  = !rsp_valid_ff || rsp.ready;
      // The input stage can take a request when empty or when it advances.
      s1_load   = !s1_valid_ff || rsp_load;
      req.ready = s1_load;

      s1_valid_in = s1_load ? req.valid : s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (s1_load && req.valid) begin
         s1_item_in.year_bcd   = req.year_bcd;
         s1_item_in.month_bcd  = req.month_bcd;
         s1_item_in.day_bcd    = req.day_bcd;
         s1_item_in.hour_bcd   = req.hour_bcd;
         s1_item_in.minute_bcd = req.minute_bcd;
         s1_item_in.second_bcd = req.second_bcd;
      end

      rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;
      rsp_epoch_in = (rsp_load && s1_valid_ff) ? calc_epoch : rsp_epoch_ff;

      rsp.valid         = rsp_valid_ff;
      rsp.epoch_seconds = rsp_epoch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      rsp_epoch_ff <= rsp_epoch_in;
   end

endmodule

// File: rtl/bdus_calc.sv
`timescale 1ns / 1ps

module bdus_calc (
   input  bdus_pkg::req_item_type       item,
   output logic [bdus_pkg::EPOCH_W-1:0] epoch_seconds
);
   import bdus_pkg::*;

   logic [DEC_W-1:0]        yy;
   logic [DEC_W-1:0]        mon;
   logic [DEC_W-1:0]        day;
   logic [DEC_W-1:0]        hr;
   logic [DEC_W-1:0]        mn;
   logic [DEC_W-1:0]        sc;
   logic [MONTH_IDX_W-1:0]  month_idx;
   logic                    leap_add;
   logic [EPOCH_W-1:0]      day_count;

   always_comb begin
      yy  = bcd_decode(item.year_bcd);
      mon = bcd_decode(DEC_W'(item.month_bcd));
      day = bcd_decode(DEC_W'(item.day_bcd));
      hr  = bcd_decode(DEC_W'(item.hour_bcd));
      mn  = bcd_decode(DEC_W'(item.minute_bcd));
      sc  = bcd_decode(DEC_W'(item.second_bcd));

      // Full months before the given one; month zero counts like January and
      // anything past December counts the whole year.
      if (mon == '0) begin
         month_idx = '0;
      end else if (mon > DEC_W'(LAST_MONTH)) begin
         month_idx = MONTH_IDX_W'(LAST_MONTH);
      end else begin
         month_idx = MONTH_IDX_W'(mon - DEC_W'(1));
      end

      leap_add = (month_idx >= MONTH_IDX_W'(MARCH_IDX)) && LEAP_FLAGS[yy];

      // Day zero steps back one day; everything wraps modulo 2^32.
      day_count = EPOCH_W'(YEAR_DAYS[yy]) + EPOCH_W'(DAYS_BEFORE_MONTH[month_idx])
                + EPOCH_W'(leap_add) + EPOCH_W'(day) - EPOCH_W'(1);

      epoch_seconds = day_count * EPOCH_W'(SEC_PER_DAY)
                    + EPOCH_W'(hr) * EPOCH_W'(SEC_PER_HOUR)
                    + EPOCH_W'(mn) * EPOCH_W'(SEC_PER_MIN)
                    + EPOCH_W'(sc);
   end

endmodule
